// ----- design/hkf_pkg.sv -----
// Package for the two-axis position/velocity Kalman filter.
// Holds widths, codes, saturating arithmetic helpers and the step program.
// No dependencies.
package hkf_pkg;

  localparam int VW = 32;
  localparam int FB = 16;
  localparam int MW = VW + FB;
  localparam int MUL_STEPS = VW;
  localparam int DIV_STEPS = MW;
  localparam int CNT_W = 6;

  localparam logic [VW-1:0] ONE_VAL = VW'(1) << FB;

  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_REALIGN = 3'd1;
  localparam logic [2:0] OP_PROP    = 3'd2;
  localparam logic [2:0] OP_UPOS    = 3'd3;
  localparam logic [2:0] OP_UVEL    = 3'd4;

  localparam logic [2:0] CFG_DT   = 3'd0;
  localparam logic [2:0] CFG_QP   = 3'd1;
  localparam logic [2:0] CFG_QV   = 3'd2;
  localparam logic [2:0] CFG_IV   = 3'd3;
  localparam logic [2:0] CFG_LIM  = 3'd4;

  localparam logic [2:0] A_ADD  = 3'd0;
  localparam logic [2:0] A_SUB  = 3'd1;
  localparam logic [2:0] A_MUL  = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_HALF = 3'd4;

  // Operand codes: state of the current axis, shared temporaries, constants.
  localparam logic [4:0] C_POS = 5'd0;
  localparam logic [4:0] C_VEL = 5'd1;
  localparam logic [4:0] C_ACC = 5'd2;
  localparam logic [4:0] C_C0  = 5'd3;
  localparam logic [4:0] C_C1  = 5'd4;
  localparam logic [4:0] C_C2  = 5'd5;
  localparam logic [4:0] C_C3  = 5'd6;
  localparam logic [4:0] T0 = 5'd8;
  localparam logic [4:0] T1 = 5'd9;
  localparam logic [4:0] T2 = 5'd10;
  localparam logic [4:0] T3 = 5'd11;
  localparam logic [4:0] T4 = 5'd12;
  localparam logic [4:0] T5 = 5'd13;
  localparam logic [4:0] T6 = 5'd14;
  localparam logic [4:0] T7 = 5'd15;
  localparam logic [4:0] K_ZERO = 5'd16;
  localparam logic [4:0] K_ONE  = 5'd17;
  localparam logic [4:0] K_DT   = 5'd18;
  localparam logic [4:0] K_QP   = 5'd19;
  localparam logic [4:0] K_QV   = 5'd20;
  localparam logic [4:0] K_IV   = 5'd21;
  localparam logic [4:0] K_Z    = 5'd22;
  localparam logic [4:0] K_R    = 5'd23;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
    logic       last;
  } uins_t;

  localparam int UC_LEN = 60;
  localparam logic [5:0] PC_INIT    = 6'd0;
  localparam logic [5:0] PC_REALIGN = 6'd6;
  localparam logic [5:0] PC_PROP    = 6'd8;
  localparam logic [5:0] PC_UPOS    = 6'd26;
  localparam logic [5:0] PC_UVEL    = 6'd43;

  function automatic uins_t mi(input logic [2:0] op, input logic [4:0] dst,
                               input logic [4:0] sa, input logic [4:0] sb,
                               input logic last);
    uins_t u;
    u.op = op;
    u.dst = dst;
    u.sa = sa;
    u.sb = sb;
    u.last = last;
    return u;
  endfunction

  localparam uins_t UCODE [0:UC_LEN-1] = '{
    mi(A_ADD, C_POS, K_Z, K_ZERO, 1'b0),
    mi(A_ADD, C_VEL, K_R, K_ZERO, 1'b0),
    mi(A_ADD, C_C0, K_IV, K_ZERO, 1'b0),
    mi(A_ADD, C_C1, K_ZERO, K_ZERO, 1'b0),
    mi(A_ADD, C_C2, K_ZERO, K_ZERO, 1'b0),
    mi(A_ADD, C_C3, K_IV, K_ZERO, 1'b1),
    mi(A_ADD, C_POS, K_Z, K_ZERO, 1'b0),
    mi(A_ADD, C_VEL, K_R, K_ZERO, 1'b1),
    mi(A_MUL, T0, K_DT, C_VEL, 1'b0),
    mi(A_MUL, T1, K_DT, K_DT, 1'b0),
    mi(A_HALF, T1, T1, K_ZERO, 1'b0),
    mi(A_MUL, T1, T1, K_Z, 1'b0),
    mi(A_ADD, T0, C_POS, T0, 1'b0),
    mi(A_ADD, C_POS, T0, T1, 1'b0),
    mi(A_MUL, T2, K_DT, K_Z, 1'b0),
    mi(A_ADD, C_VEL, C_VEL, T2, 1'b0),
    mi(A_ADD, C_ACC, K_Z, K_ZERO, 1'b0),
    mi(A_MUL, T3, K_DT, C_C3, 1'b0),
    mi(A_ADD, T4, C_C2, C_C1, 1'b0),
    mi(A_ADD, T4, T4, T3, 1'b0),
    mi(A_MUL, T4, K_DT, T4, 1'b0),
    mi(A_ADD, T4, C_C0, T4, 1'b0),
    mi(A_ADD, C_C0, T4, K_QP, 1'b0),
    mi(A_ADD, C_C1, C_C1, T3, 1'b0),
    mi(A_ADD, C_C2, C_C2, T3, 1'b0),
    mi(A_ADD, C_C3, C_C3, K_QV, 1'b1),
    mi(A_SUB, T0, K_Z, C_POS, 1'b0),
    mi(A_ADD, T1, C_C0, K_R, 1'b0),
    mi(A_DIV, T2, C_C0, T1, 1'b0),
    mi(A_DIV, T3, C_C2, T1, 1'b0),
    mi(A_SUB, T4, K_ONE, T2, 1'b0),
    mi(A_MUL, T5, T4, C_C0, 1'b0),
    mi(A_MUL, T6, T4, C_C1, 1'b0),
    mi(A_MUL, T7, T3, C_C0, 1'b0),
    mi(A_SUB, C_C2, C_C2, T7, 1'b0),
    mi(A_MUL, T7, T3, C_C1, 1'b0),
    mi(A_SUB, C_C3, C_C3, T7, 1'b0),
    mi(A_ADD, C_C0, T5, K_ZERO, 1'b0),
    mi(A_ADD, C_C1, T6, K_ZERO, 1'b0),
    mi(A_MUL, T7, T2, T0, 1'b0),
    mi(A_ADD, C_POS, C_POS, T7, 1'b0),
    mi(A_MUL, T7, T3, T0, 1'b0),
    mi(A_ADD, C_VEL, C_VEL, T7, 1'b1),
    mi(A_SUB, T0, K_Z, C_VEL, 1'b0),
    mi(A_ADD, T1, C_C3, K_R, 1'b0),
    mi(A_DIV, T2, C_C1, T1, 1'b0),
    mi(A_DIV, T3, C_C3, T1, 1'b0),
    mi(A_SUB, T4, K_ONE, T3, 1'b0),
    mi(A_MUL, T5, T2, C_C2, 1'b0),
    mi(A_SUB, T5, C_C0, T5, 1'b0),
    mi(A_MUL, T6, T2, C_C3, 1'b0),
    mi(A_SUB, T6, C_C1, T6, 1'b0),
    mi(A_MUL, C_C2, T4, C_C2, 1'b0),
    mi(A_MUL, C_C3, T4, C_C3, 1'b0),
    mi(A_ADD, C_C0, T5, K_ZERO, 1'b0),
    mi(A_ADD, C_C1, T6, K_ZERO, 1'b0),
    mi(A_MUL, T7, T2, T0, 1'b0),
    mi(A_ADD, C_POS, C_POS, T7, 1'b0),
    mi(A_MUL, T7, T3, T0, 1'b0),
    mi(A_ADD, C_VEL, C_VEL, T7, 1'b1)
  };

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    return s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_sub(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    return s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] mag(input logic [VW-1:0] a);
    return a[VW-1] ? (VW'(0) - a) : a;
  endfunction

  function automatic logic [VW-1:0] sat_mag(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [VW-1:0] v;
    lim = neg ? (MW'(1) << (VW - 1)) : ((MW'(1) << (VW - 1)) - MW'(1));
    v = (m > lim) ? lim[VW-1:0] : m[VW-1:0];
    return neg ? (VW'(0) - v) : v;
  endfunction

endpackage

// ----- design/horizontal_kalman_pos_vel.sv -----
// Each program step reads both operands, sets up, runs the bit-serial multiplier or
// divider if the step needs it, and writes back; both axes run the program in turn.
// Propagate skips its program once the lost limit is reached, and an undefined operation
// runs no program; one item is taken at a time.
// After reset a pass loads the register file before the first item is taken.
// Top level of the two-axis Kalman filter; depends on hkf_pkg.
module horizontal_kalman_pos_vel
  import hkf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [22:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_operation,
  input  logic signed [31:0]   in_first_x,
  input  logic signed [31:0]   in_first_y,
  input  logic signed [31:0]   in_second_x,
  input  logic signed [31:0]   in_second_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_est_pos_x,
  output logic signed [31:0]   out_est_vel_x,
  output logic signed [31:0]   out_est_acc_x,
  output logic signed [31:0]   out_est_pos_y,
  output logic signed [31:0]   out_est_vel_y,
  output logic signed [31:0]   out_est_acc_y,
  output logic signed [31:0]   out_var_pos_x,
  output logic signed [31:0]   out_var_vel_x,
  output logic signed [31:0]   out_var_pos_y,
  output logic signed [31:0]   out_var_vel_y,
  output logic                 out_fix_lost
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_FA   = 3'd2;
  localparam logic [2:0] S_FB   = 3'd3;
  localparam logic [2:0] S_SET  = 3'd4;
  localparam logic [2:0] S_EX   = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state_r;
  logic [16:0]   dt_r, qp_r, qv_r;
  logic [22:0]   iv_r;
  logic [15:0]   lim_r, cnt_r, cnt_inc;
  logic [VW-1:0] fx_r, fy_r, sx_r, sy_r;
  logic [5:0]    pc_r, start_r;
  logic          axis_r;
  logic [4:0]    clr_r;
  logic [CNT_W-1:0] ex_cnt_r;
  uins_t         uin;

  logic [VW-1:0] rf_mem [0:31];
  logic [4:0]    rd_addr;
  logic [4:0]    rd_code;
  logic [VW-1:0] rd_data_r, cst_r, cst_val, opa_r, opb_w, res_r, wb_val;
  logic          use_cst_r;

  logic          mem_we;
  logic [4:0]    mem_wa;
  logic [VW-1:0] mem_wd;

  logic [VW-1:0] ma_r, hi_r, lo_r;
  logic [VW:0]   mul_sum;
  logic [2*VW-1:0] prod_rnd;
  logic          neg_r, dz_r;
  logic [VW-1:0] d_r, r_r;
  logic [MW-1:0] n_r, q_r;
  logic [VW:0]   r_sh;

  logic [VW-1:0] sh_pos_r [0:1];
  logic [VW-1:0] sh_vel_r [0:1];
  logic [VW-1:0] sh_acc_r [0:1];
  logic [VW-1:0] sh_c0_r  [0:1];
  logic [VW-1:0] sh_c3_r  [0:1];

  assign uin = UCODE[pc_r];
  assign in_ready = (state_r == S_IDLE);
  assign cnt_inc = (cnt_r < lim_r) ? cnt_r + 16'd1 : cnt_r;

  function automatic logic [4:0] rf_addr(input logic [4:0] code, input logic ax);
    return code[3] ? {2'b10, code[2:0]} : {1'b0, ax, code[2:0]};
  endfunction

  always_comb begin
    rd_code = (state_r == S_FA) ? uin.sa : uin.sb;
    rd_addr = rf_addr(rd_code, axis_r);
    case (rd_code)
      K_ONE:   cst_val = ONE_VAL;
      K_DT:    cst_val = {15'd0, dt_r};
      K_QP:    cst_val = {15'd0, qp_r};
      K_QV:    cst_val = {15'd0, qv_r};
      K_IV:    cst_val = {9'd0, iv_r};
      K_Z:     cst_val = axis_r ? fy_r : fx_r;
      K_R:     cst_val = axis_r ? sy_r : sx_r;
      default: cst_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rf_mem[rd_addr];
    cst_r <= cst_val;
    use_cst_r <= rd_code[4];
    if (mem_we) begin
      rf_mem[mem_wa] <= mem_wd;
    end
  end

  assign opb_w = use_cst_r ? cst_r : rd_data_r;
  assign mul_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ma_r} : '0);
  assign prod_rnd = {hi_r, lo_r} + (64'd1 << (FB - 1));
  assign r_sh = {r_r, n_r[MW-1]};

  always_comb begin
    case (uin.op)
      A_MUL:   wb_val = sat_mag(neg_r, prod_rnd[2*VW-1:FB]);
      A_DIV:   wb_val = dz_r ? '0 : sat_mag(neg_r, q_r);
      default: wb_val = res_r;
    endcase
    mem_we = 1'b0;
    mem_wa = rf_addr(uin.dst, axis_r);
    mem_wd = wb_val;
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = (!clr_r[4] && (clr_r[2:0] == C_C0[2:0] || clr_r[2:0] == C_C3[2:0])) ?
               ONE_VAL : '0;
    end else if (state_r == S_WB) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && !mem_wa[4]) begin
      case (mem_wa[2:0])
        C_POS[2:0]: sh_pos_r[mem_wa[3]] <= mem_wd;
        C_VEL[2:0]: sh_vel_r[mem_wa[3]] <= mem_wd;
        C_ACC[2:0]: sh_acc_r[mem_wa[3]] <= mem_wd;
        C_C0[2:0]:  sh_c0_r[mem_wa[3]] <= mem_wd;
        C_C3[2:0]:  sh_c3_r[mem_wa[3]] <= mem_wd;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 17'd2048;
      qp_r <= 17'd16;
      qv_r <= 17'd1024;
      iv_r <= 23'd65536;
      lim_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DT:  dt_r <= cfg_data[16:0];
        CFG_QP:  qp_r <= cfg_data[16:0];
        CFG_QV:  qv_r <= cfg_data[16:0];
        CFG_IV:  iv_r <= cfg_data;
        CFG_LIM: lim_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        fx_r <= in_first_x;
        fy_r <= in_first_y;
        sx_r <= in_second_x;
        sy_r <= in_second_y;
      end
      S_FB: opa_r <= use_cst_r ? cst_r : rd_data_r;
      S_SET: begin
        neg_r <= opa_r[VW-1] ^ opb_w[VW-1];
        case (uin.op)
          A_ADD: res_r <= sat_add(opa_r, opb_w);
          A_SUB: res_r <= sat_sub(opa_r, opb_w);
          A_HALF: res_r <= VW'($signed(opa_r + VW'(opa_r[VW-1])) >>> 1);
          default: res_r <= '0;
        endcase
        ma_r <= mag(opa_r);
        hi_r <= '0;
        lo_r <= mag(opb_w);
        d_r <= mag(opb_w);
        dz_r <= (opb_w == '0);
        n_r <= {mag(opa_r), {FB{1'b0}}} + MW'(mag(opb_w) >> 1);
        r_r <= '0;
        q_r <= '0;
      end
      S_EX: begin
        if (uin.op == A_MUL) begin
          hi_r <= mul_sum[VW:1];
          lo_r <= {mul_sum[0], lo_r[VW-1:1]};
        end else begin
          n_r <= {n_r[MW-2:0], 1'b0};
          if (r_sh >= {1'b0, d_r}) begin
            r_r <= VW'(r_sh - {1'b0, d_r});
            q_r <= {q_r[MW-2:0], 1'b1};
          end else begin
            r_r <= r_sh[VW-1:0];
            q_r <= {q_r[MW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cnt_r <= '0;
      pc_r <= '0;
      start_r <= '0;
      axis_r <= 1'b0;
      ex_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state_r != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 5'd1;
          if (clr_r == 5'd31) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            axis_r <= 1'b0;
            state_r <= S_FA;
            case (in_operation)
              OP_INIT: begin
                cnt_r <= '0;
                pc_r <= PC_INIT;
                start_r <= PC_INIT;
              end
              OP_REALIGN: begin
                pc_r <= PC_REALIGN;
                start_r <= PC_REALIGN;
              end
              OP_PROP: begin
                cnt_r <= cnt_inc;
                pc_r <= PC_PROP;
                start_r <= PC_PROP;
                if (cnt_inc >= lim_r) begin
                  state_r <= S_DONE;
                end
              end
              OP_UPOS: begin
                cnt_r <= '0;
                pc_r <= PC_UPOS;
                start_r <= PC_UPOS;
              end
              OP_UVEL: begin
                pc_r <= PC_UVEL;
                start_r <= PC_UVEL;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_FA: state_r <= S_FB;
        S_FB: state_r <= S_SET;
        S_SET: begin
          ex_cnt_r <= '0;
          state_r <= (uin.op == A_MUL || uin.op == A_DIV) ? S_EX : S_WB;
        end
        S_EX: begin
          ex_cnt_r <= ex_cnt_r + CNT_W'(1);
          if ((uin.op == A_MUL && ex_cnt_r == CNT_W'(MUL_STEPS - 1)) ||
              ex_cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          if (uin.last) begin
            if (!axis_r) begin
              axis_r <= 1'b1;
              pc_r <= start_r;
              state_r <= S_FA;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            pc_r <= pc_r + 6'd1;
            state_r <= S_FA;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid || out_ready)) begin
      out_est_pos_x <= sh_pos_r[0];
      out_est_vel_x <= sh_vel_r[0];
      out_est_acc_x <= sh_acc_r[0];
      out_est_pos_y <= sh_pos_r[1];
      out_est_vel_y <= sh_vel_r[1];
      out_est_acc_y <= sh_acc_r[1];
      out_var_pos_x <= sh_c0_r[0];
      out_var_vel_x <= sh_c3_r[0];
      out_var_pos_y <= sh_c0_r[1];
      out_var_vel_y <= sh_c3_r[1];
      out_fix_lost <= (cnt_r >= lim_r);
    end
  end

  a_ex_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EX) |-> (ex_cnt_r < CNT_W'(DIV_STEPS)))
    else $error("Serial step count ran past the divider length.");

  a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && uin.last && axis_r) |=> (state_r == S_DONE))
    else $error("Second axis finished without completing the item.");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_DONE))
    else $error("Result raised outside the completion state.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("Accepted item did not start.");

endmodule
